### rtl/csihex_pkg.sv
// ----------------------------------------------------------------------------
// csihex_pkg
// Shared constants, types and the hex digit decoder of the amplitude extractor.
// ----------------------------------------------------------------------------
package csihex_pkg;

    localparam int NUM_SUBCARRIERS = 64;
    localparam int SKIP_LOW        = 29;
    localparam int SKIP_HIGH       = 35;
    localparam int LAST_KEPT       = (NUM_SUBCARRIERS - 1 > SKIP_HIGH) ?
                                     (NUM_SUBCARRIERS - 1) : (SKIP_LOW - 1);
    localparam int ROOT_STEPS      = 24;

    typedef struct packed {
        logic       wr_nib;
        logic [2:0] wr_pos;
        logic       capture;
        logic       real_err;
        logic       imag_err;
        logic [5:0] feat_idx;
        logic       bad;
        logic       last;
        logic       sq_re;
        logic       sq_im;
        logic       sum;
        logic       root_step;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic       digit_ok;
    } t_status;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

### rtl/csihex_datapath.sv
// ----------------------------------------------------------------------------
// csihex_datapath
// Nibble buffer, word assembly, squaring, bit-serial square root and the
// output register of the amplitude extractor.
// ----------------------------------------------------------------------------
module csihex_datapath
    import csihex_pkg::*;
(
    input  logic               i_clk,
    input  logic [7:0]         i_char_code,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic [5:0]         o_feature_index,
    output logic signed [15:0] o_real_part,
    output logic signed [15:0] o_imag_part,
    output logic [23:0]        o_amplitude,
    output logic               o_bad_digit,
    output logic               o_last_feature
);

    logic [4:0]  dec;
    logic [3:0]  r_nib [7];
    logic [15:0] r_re;
    logic [15:0] r_im;
    logic [5:0]  r_feat;
    logic        r_bad;
    logic        r_last;
    logic [31:0] r_prod;
    logic [31:0] r_acc;
    logic [47:0] r_xsh;
    logic [25:0] r_rem;
    logic [23:0] r_root;
    logic [15:0] mag_re;
    logic [15:0] mag_im;
    logic [15:0] mag_sel;
    logic [31:0] rad;
    logic [27:0] rem_sh;
    logic [27:0] trial;
    logic [15:0] word_re;
    logic [15:0] word_im;

    logic [5:0]  r_o_feat;
    logic [15:0] r_o_re;
    logic [15:0] r_o_im;
    logic [23:0] r_o_amp;
    logic        r_o_bad;
    logic        r_o_last;

    assign dec               = hex_decode(i_char_code);
    assign o_status.digit_ok = dec[4];

    assign word_re = {r_nib[2], r_nib[3], r_nib[0], r_nib[1]};
    assign word_im = {r_nib[6], dec[3:0], r_nib[4], r_nib[5]};

    assign mag_re  = r_re[15] ? (~r_re + 16'd1) : r_re;
    assign mag_im  = r_im[15] ? (~r_im + 16'd1) : r_im;
    assign mag_sel = i_cmd.sq_im ? mag_im : mag_re;
    assign rad     = r_acc + r_prod;
    assign rem_sh  = {r_rem, r_xsh[47:46]};
    assign trial   = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_nib) begin
            r_nib[i_cmd.wr_pos] <= dec[3:0];
        end
        if (i_cmd.capture) begin
            r_re   <= i_cmd.real_err ? 16'd0 : word_re;
            r_im   <= i_cmd.imag_err ? 16'd0 : word_im;
            r_feat <= i_cmd.feat_idx;
            r_bad  <= i_cmd.bad;
            r_last <= i_cmd.last;
        end
        if (i_cmd.sq_re || i_cmd.sq_im) begin
            r_prod <= {16'd0, mag_sel} * {16'd0, mag_sel};
        end
        if (i_cmd.sq_im) begin
            r_acc <= r_prod;
        end
        if (i_cmd.sum) begin
            r_xsh  <= {rad, 16'd0};
            r_rem  <= 26'd0;
            r_root <= 24'd0;
        end
        if (i_cmd.root_step) begin
            r_xsh <= {r_xsh[45:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= 26'(rem_sh - trial);
                r_root <= {r_root[22:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[25:0];
                r_root <= {r_root[22:0], 1'b0};
            end
        end
        if (i_cmd.load_out) begin
            r_o_feat <= r_feat;
            r_o_re   <= r_re;
            r_o_im   <= r_im;
            r_o_amp  <= r_root;
            r_o_bad  <= r_bad;
            r_o_last <= r_last;
        end
    end

    assign o_feature_index = r_o_feat;
    assign o_real_part     = signed'(r_o_re);
    assign o_imag_part     = signed'(r_o_im);
    assign o_amplitude     = r_o_amp;
    assign o_bad_digit     = r_o_bad;
    assign o_last_feature  = r_o_last;

endmodule

### rtl/csihex_ctrl.sv
// ----------------------------------------------------------------------------
// csihex_ctrl
// Controller of the amplitude extractor: character and subcarrier counting,
// error tracking and sequencing of the squaring and square root steps.
// ----------------------------------------------------------------------------
module csihex_ctrl
    import csihex_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_msg_start,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQR  = 3'd1;
    localparam logic [2:0] ST_SQI  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_ROOT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] r_state, n_state;
    logic [2:0] r_pos, n_pos;
    logic [5:0] r_sc, n_sc;
    logic [5:0] r_fc, n_fc;
    logic       r_derr, n_derr;
    logic       r_rerr, n_rerr;
    logic       r_ierr, n_ierr;
    logic [4:0] r_iter, n_iter;
    logic       r_oval, n_oval;

    logic       take;
    logic [2:0] pos;
    logic [5:0] sc;
    logic [5:0] fc;
    logic       derr;
    logic       rerr;
    logic       ierr;
    logic       kept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_oval;
    assign take        = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        pos  = i_msg_start ? 3'd0 : r_pos;
        sc   = i_msg_start ? 6'd0 : r_sc;
        fc   = i_msg_start ? 6'd0 : r_fc;
        derr = (pos == 3'd0) ? 1'b0 : r_derr;
        rerr = (pos == 3'd0) ? 1'b0 : r_rerr;
        ierr = (pos == 3'd0) ? 1'b0 : r_ierr;
        if (!i_status.digit_ok) begin
            derr = 1'b1;
            if (pos[2]) begin
                ierr = 1'b1;
            end else begin
                rerr = 1'b1;
            end
        end
        kept = ((sc > 6'd0) && (sc < 6'(SKIP_LOW))) || (sc > 6'(SKIP_HIGH));

        n_state = r_state;
        n_pos   = r_pos;
        n_sc    = r_sc;
        n_fc    = r_fc;
        n_derr  = r_derr;
        n_rerr  = r_rerr;
        n_ierr  = r_ierr;
        n_iter  = r_iter;
        n_oval  = r_oval;

        o_cmd           = '0;
        o_cmd.wr_pos    = pos;
        o_cmd.real_err  = rerr;
        o_cmd.imag_err  = ierr;
        o_cmd.feat_idx  = fc;
        o_cmd.bad       = derr;
        o_cmd.last      = (sc == 6'(LAST_KEPT));

        if (r_oval && i_out_ready) begin
            n_oval = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_derr = derr;
                    n_rerr = rerr;
                    n_ierr = ierr;
                    if (pos != 3'd7) begin
                        o_cmd.wr_nib = 1'b1;
                        n_pos        = pos + 3'd1;
                        n_sc         = sc;
                        n_fc         = fc;
                    end else begin
                        n_pos = 3'd0;
                        n_fc  = fc;
                        if (kept) begin
                            o_cmd.capture = 1'b1;
                            n_fc          = fc + 6'd1;
                            n_state       = ST_SQR;
                        end
                        if (sc >= 6'(NUM_SUBCARRIERS - 1)) begin
                            n_sc = 6'd0;
                            n_fc = 6'd0;
                        end else begin
                            n_sc = sc + 6'd1;
                        end
                    end
                end
            end
            ST_SQR: begin
                o_cmd.sq_re = 1'b1;
                n_state     = ST_SQI;
            end
            ST_SQI: begin
                o_cmd.sq_im = 1'b1;
                n_state     = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_iter    = 5'd0;
                n_state   = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_iter          = r_iter + 5'd1;
                if (r_iter == 5'(ROOT_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_oval || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_oval         = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= 3'd0;
            r_sc    <= 6'd0;
            r_fc    <= 6'd0;
            r_derr  <= 1'b0;
            r_rerr  <= 1'b0;
            r_ierr  <= 1'b0;
            r_iter  <= 5'd0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_sc    <= n_sc;
            r_fc    <= n_fc;
            r_derr  <= n_derr;
            r_rerr  <= n_rerr;
            r_ierr  <= n_ierr;
            r_iter  <= n_iter;
            r_oval  <= n_oval;
        end
    end

endmodule

### rtl/csi_hex_amplitude_extractor.sv
// ----------------------------------------------------------------------------
// csi_hex_amplitude_extractor
// One character is taken per cycle while idle. The eighth character of a kept
// subcarrier starts the squaring and a 24-step bit-serial square root; no
// character is taken until the result is loaded into the output register, and
// a skipped subcarrier does not stall the input. Reset is synchronous and
// active low; it clears all counters and empties the output register.
// ----------------------------------------------------------------------------
module csi_hex_amplitude_extractor
    import csihex_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_code,
    input  logic               i_msg_start,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [5:0]         o_feature_index,
    output logic signed [15:0] o_real_part,
    output logic signed [15:0] o_imag_part,
    output logic [23:0]        o_amplitude,
    output logic               o_bad_digit,
    output logic               o_last_feature
);

    t_cmd    cmd;
    t_status status;

    csihex_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_msg_start (i_msg_start),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    csihex_datapath u_datapath (
        .i_clk           (i_clk),
        .i_char_code     (i_char_code),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_feature_index (o_feature_index),
        .o_real_part     (o_real_part),
        .o_imag_part     (o_imag_part),
        .o_amplitude     (o_amplitude),
        .o_bad_digit     (o_bad_digit),
        .o_last_feature  (o_last_feature)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives hex channel-state characters into the amplitude extractor and checks
// every feature it returns against a predictor of its own. A short directed
// stream comes first. Random messages follow: full, overlong, short and cut
// off in mid-group. Both sides idle at random in phases, and once the
// receiver holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module testbench;
    import csihex_pkg::*;

    localparam int ITEMS      = 1450;
    localparam int HOLD_AT    = 150;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN      = 40;
    localparam int CYCLE_CAP  = 300000;

    typedef struct packed {
        logic [7:0] code;
        logic       start;
    } t_char;

    typedef struct packed {
        logic [5:0]         feat_idx;
        logic signed [15:0] re_part;
        logic signed [15:0] im_part;
        logic [23:0]        amp;
        logic               bad;
        logic               is_last;
    } t_feature;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [7:0]         i_char_code;
    logic               i_msg_start;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [5:0]         o_feature_index;
    logic signed [15:0] o_real_part;
    logic signed [15:0] o_imag_part;
    logic [23:0]        o_amplitude;
    logic               o_bad_digit;
    logic               o_last_feature;

    t_char    chars_pending[$];
    t_feature features_due[$];

    logic [2:0] chars_in_group;
    logic [5:0] carrier_no;
    logic [3:0] nibbles [0:6];
    logic       group_bad;
    logic       real_bad;
    logic       imag_bad;
    logic [5:0] feature_no;

    int   chars_total;
    int   chars_taken;
    int   mismatches;
    int   cycles;
    int   hold_left;
    logic hold_done;
    logic [1:0] idle_mode;

    csi_hex_amplitude_extractor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_char_code     (i_char_code),
        .i_msg_start     (i_msg_start),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_feature_index (o_feature_index),
        .o_real_part     (o_real_part),
        .o_imag_part     (o_imag_part),
        .o_amplitude     (o_amplitude),
        .o_bad_digit     (o_bad_digit),
        .o_last_feature  (o_last_feature)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = c[3:0];
            return 1'b1;
        end
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = 4'(c[2:0] + 4'd9);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [23:0] amplitude_of(input logic [15:0] re, input logic [15:0] im);
        logic [16:0] ar;
        logic [16:0] ai;
        logic [63:0] radicand;
        logic [23:0] root;
        logic [23:0] trial;
        ar = re[15] ? (17'h10000 - {1'b0, re}) : {1'b0, re};
        ai = im[15] ? (17'h10000 - {1'b0, im}) : {1'b0, im};
        radicand = (64'(ar) * 64'(ar) + 64'(ai) * 64'(ai)) << 16;
        root = 24'd0;
        for (int b = 23; b >= 0; b--) begin
            trial = root | (24'd1 << b);
            if (64'(trial) * 64'(trial) <= radicand) begin
                root = trial;
            end
        end
        return root;
    endfunction

    task automatic take_char(input logic [7:0] code, input logic start);
        logic [3:0]  nib;
        logic        ok;
        logic [15:0] re_w;
        logic [15:0] im_w;
        t_feature    f;
        ok = hex_nibble(code, nib);
        if (start) begin
            chars_in_group = 3'd0;
            carrier_no     = 6'd0;
            feature_no     = 6'd0;
        end
        if (chars_in_group == 3'd0) begin
            group_bad = 1'b0;
            real_bad  = 1'b0;
            imag_bad  = 1'b0;
        end
        if (!ok) begin
            group_bad = 1'b1;
            if (chars_in_group >= 3'd4) begin
                imag_bad = 1'b1;
            end else begin
                real_bad = 1'b1;
            end
        end
        if (chars_in_group != 3'd7) begin
            nibbles[chars_in_group] = nib;
            chars_in_group++;
        end else begin
            if ((carrier_no > 0 && carrier_no < SKIP_LOW) || carrier_no > SKIP_HIGH) begin
                re_w = {nibbles[2], nibbles[3], nibbles[0], nibbles[1]};
                im_w = {nibbles[6], nib, nibbles[4], nibbles[5]};
                if (real_bad) begin
                    re_w = 16'd0;
                end
                if (imag_bad) begin
                    im_w = 16'd0;
                end
                f.feat_idx = feature_no;
                f.re_part  = re_w;
                f.im_part  = im_w;
                f.amp      = amplitude_of(re_w, im_w);
                f.bad      = group_bad;
                f.is_last  = (carrier_no == LAST_KEPT);
                features_due.push_back(f);
                feature_no++;
            end
            if (carrier_no >= NUM_SUBCARRIERS - 1) begin
                carrier_no = 6'd0;
                feature_no = 6'd0;
            end else begin
                carrier_no++;
            end
            chars_in_group = 3'd0;
        end
    endtask

    task automatic compare_field(input string what, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + 8'(v);
        end
        return ($urandom_range(1, 0) ? 8'h61 : 8'h41) + 8'(v - 4'd10);
    endfunction

    task automatic push_char(input logic [7:0] code, input logic start);
        t_char c;
        c.code  = code;
        c.start = start;
        chars_pending.push_back(c);
    endtask

    task automatic push_text(input string s, input logic start);
        for (int k = 0; k < s.len(); k++) begin
            push_char(s[k], start && k == 0);
        end
    endtask

    function automatic logic [15:0] random_word();
        logic [15:0] corner [0:3];
        corner = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        if ($urandom_range(7, 0) == 0) begin
            return corner[$urandom_range(3, 0)];
        end
        return 16'($urandom);
    endfunction

    task automatic push_random_group(input logic start);
        logic [15:0] re_w;
        logic [15:0] im_w;
        logic [7:0]  chars [0:7];
        re_w = random_word();
        im_w = random_word();
        chars = '{hex_char(re_w[7:4]), hex_char(re_w[3:0]),
                  hex_char(re_w[15:12]), hex_char(re_w[11:8]),
                  hex_char(im_w[7:4]), hex_char(im_w[3:0]),
                  hex_char(im_w[15:12]), hex_char(im_w[11:8])};
        if ($urandom_range(99, 0) < 15) begin
            chars[$urandom_range(7, 0)] = 8'($urandom_range(255, 0));
        end
        for (int k = 0; k < 8; k++) begin
            push_char(chars[k], start && k == 0);
        end
    endtask

    // The driver predicts each character as it is transferred and then offers
    // the next one, unless it is idling.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                take_char(i_char_code, i_msg_start);
                chars_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (chars_pending.size() > 0 &&
                    !(idle_mode == 2'd1 && $urandom_range(99, 0) < 69) &&
                    !(idle_mode == 2'd3 && $urandom_range(99, 0) < 14)) begin
                    i_in_valid  <= 1'b1;
                    i_char_code <= chars_pending[0].code;
                    i_msg_start <= chars_pending[0].start;
                    void'(chars_pending.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (chars_taken < chars_total / 4) begin
            idle_mode <= 2'd0;
        end else if (chars_taken < chars_total / 2) begin
            idle_mode <= 2'd1;
        end else if (chars_taken < 3 * chars_total / 4) begin
            idle_mode <= 2'd2;
        end else begin
            idle_mode <= 2'd3;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (features_due.size() == 0) begin
                    $display("%0t: unexpected feature %0d, expected none", $time,
                             o_feature_index);
                    mismatches++;
                end else begin
                    compare_field("feature_index", features_due[0].feat_idx, o_feature_index);
                    compare_field("real_part", features_due[0].re_part, o_real_part);
                    compare_field("imag_part", features_due[0].im_part, o_imag_part);
                    compare_field("amplitude", features_due[0].amp, o_amplitude);
                    compare_field("bad_digit", features_due[0].bad, o_bad_digit);
                    compare_field("last_feature", features_due[0].is_last, o_last_feature);
                    void'(features_due.pop_front());
                end
            end
            if (!hold_done && chars_taken >= HOLD_AT) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !((idle_mode == 2'd2 && $urandom_range(99, 0) < 69) ||
                                 (idle_mode == 2'd3 && $urandom_range(99, 0) < 14));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int groups;
        int cut;
        int msg;
        chars_in_group = 3'd0;
        carrier_no     = 6'd0;
        feature_no     = 6'd0;
        group_bad      = 1'b0;
        real_bad       = 1'b0;
        imag_bad       = 1'b0;
        chars_taken    = 0;
        mismatches     = 0;
        cycles         = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        idle_mode      = 2'd0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_char_code <= 8'h00;
        i_msg_start <= 1'b0;
        i_out_ready <= 1'b0;

        // Characters before any message start, the most negative pair, the
        // largest positive real part with a bad imaginary half, and a group
        // cut short by the next message start.
        push_text("Aa9F0fF0", 1'b0);
        push_text("00800080", 1'b0);
        push_text("ff7fG/`g", 1'b0);
        push_text("@:", 1'b0);
        push_char(8'h00, 1'b0);
        push_char(8'hff, 1'b0);

        msg = 0;
        while (chars_pending.size() < ITEMS) begin
            groups = (msg == 0) ? 64 : (msg == 1) ? 70 : $urandom_range(24, 1);
            for (int g = 0; g < groups; g++) begin
                push_random_group(g == 0);
            end
            if ($urandom_range(9, 0) == 0) begin
                cut = $urandom_range(7, 1);
                for (int k = 0; k < cut; k++) begin
                    push_char(hex_char(4'($urandom)), 1'b0);
                end
            end
            msg++;
        end
        chars_total = chars_pending.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (chars_pending.size() == 0 && !i_in_valid);
        wait (features_due.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && features_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
